[src/hdbl_pkg.sv]
// Package for the Hensel divide-by-limb block: sequencer states, command codes,
// and the control and status structs of the shared shift/add/subtract unit.
// No dependencies.
package hdbl_pkg;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIX   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIVISOR = 2'd1;

   localparam logic [1:0] CMD_NEXT  = 2'd0;
   localparam logic [1:0] CMD_FIRST = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      logic         long_run;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_B,
      ST_EUC_TEST,
      ST_EUC_DIV,
      ST_EUC_QMOD,
      ST_EUC_MUL,
      ST_EUC_MRED,
      ST_EUC_UPD,
      ST_CHECK,
      ST_RED_A,
      ST_RED_C,
      ST_SUBW,
      ST_RED_INV,
      ST_QMUL,
      ST_QRED,
      ST_PMUL,
      ST_PDIV,
      ST_RESP
   } state_type;

endpackage

[src/hdbl_arith.sv]
// Shared bit-serial unit: shift-add multiply (double-width product) and
// restoring division of a double-width numerator, one bit per cycle.
// Depends on hdbl_pkg.
module hdbl_arith import hdbl_pkg::*; #(
   parameter int LIMB_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  arith_cmd_type            cmd,
   input  logic [2*LIMB_BITS-1:0]   wide_init,
   input  logic [LIMB_BITS-1:0]     mplr,
   input  logic [LIMB_BITS-1:0]     aux,
   output logic [2*LIMB_BITS-1:0]   wide_out,
   output logic [LIMB_BITS-1:0]     rem_out,
   output logic [LIMB_BITS-1:0]     quo_out,
   output arith_stat_type           stat
);

   localparam int CW = $clog2(2*LIMB_BITS+1);

   logic [2*LIMB_BITS-1:0] wide_ff, wide_in;
   logic [LIMB_BITS-1:0]   quo_ff, quo_in;
   logic [LIMB_BITS-1:0]   aux_ff, aux_in;
   logic [LIMB_BITS-1:0]   rem_ff, rem_in;
   arith_op_type           op_ff, op_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [LIMB_BITS:0]     trial;
   logic [LIMB_BITS:0]     diff;
   logic                   ge;

   assign trial = {rem_ff, wide_ff[2*LIMB_BITS-1]};
   assign diff  = trial - {1'b0, aux_ff};
   assign ge    = (trial >= {1'b0, aux_ff});

   always_comb begin
      wide_in = wide_ff;
      quo_in  = quo_ff;
      aux_in  = aux_ff;
      rem_in  = rem_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         wide_in = wide_init;
         quo_in  = mplr;
         aux_in  = aux;
         rem_in  = '0;
         op_in   = cmd.op;
         cnt_in  = cmd.long_run ? CW'(2*LIMB_BITS) : CW'(LIMB_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               wide_in = {wide_ff[2*LIMB_BITS-2:0], 1'b0}
                       + (quo_ff[LIMB_BITS-1] ? {{LIMB_BITS{1'b0}}, aux_ff}
                                               : {(2*LIMB_BITS){1'b0}});
               quo_in  = {quo_ff[LIMB_BITS-2:0], 1'b0};
            end
            OP_DIV: begin
               rem_in  = ge ? diff[LIMB_BITS-1:0] : trial[LIMB_BITS-1:0];
               wide_in = {wide_ff[2*LIMB_BITS-2:0], 1'b0};
               quo_in  = {quo_ff[LIMB_BITS-2:0], ge};
            end
            default: begin
               wide_in = wide_ff;
            end
         endcase
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      wide_ff <= wide_in;
      quo_ff  <= quo_in;
      aux_ff  <= aux_in;
      rem_ff  <= rem_in;
      op_ff   <= op_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign wide_out  = wide_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("unit started while busy");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished run");

endmodule

[src/hensel_divide_by_limb_top.sv]
// Hensel divide-by-limb: divides a multi-limb number, least significant limb
// first, by one limb in a programmable radix. Top level: sequencer and registers.
// Depends on hdbl_pkg and hdbl_arith.
//
// One word in, one word out per limb (the unused command gives no word). The
// multiplies and divisions run on one bit-serial shift-add/subtract unit, one
// bit per cycle, so cost scales with LIMB_BITS (W); the modular subtractions
// are combinational. A closing limb stops after the subtraction w = (a - c)
// mod B, and a first limb adds the extended Euclid inverse, at most about
// 1.5*W Euclid rounds. A radix below two skips the arithmetic and answers a
// flagged zero limb; a flagged run answers a flagged zero limb without the dividend steps.
// The block takes no new word until the current one is finished; the result
// register lets it take the next word while the last result waits.
module hensel_divide_by_limb_top import hdbl_pkg::*; #(
   parameter int LIMB_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [LIMB_BITS-1:0]    req_dividend_limb,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LIMB_BITS-1:0]    rsp_result_limb,
   output logic                    rsp_is_remainder,
   output logic                    rsp_not_invertible,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [LIMB_BITS-1:0]    csr_data
);

   localparam int W = LIMB_BITS;

   function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      sub_mod = (x >= y) ? (x - y) : (x + (m - y));
   endfunction

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   logic [W-1:0] radix_ff, divisor_ff;
   logic [W-1:0] carry_ff, carry_in;
   logic [W-1:0] dinv_ff, dinv_in;
   logic         miss_ff, miss_in;
   logic [1:0]   cmd_ff, cmd_in;
   logic [W-1:0] limb_ff, limb_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] c_ff, c_in;
   logic [W-1:0] qq_ff, qq_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [W-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0] out_limb_ff, out_limb_in;
   logic         out_flag_ff, out_flag_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_limb_ff, rsp_limb_in;
   logic         rsp_rem_ff, rsp_rem_in;
   logic         rsp_ninv_ff, rsp_ninv_in;

   arith_cmd_type  acmd;
   arith_stat_type astat;
   logic [2*W-1:0] a_wide_init, a_wide;
   logic [W-1:0]   a_mplr, a_aux, a_rem, a_quo;

   logic req_take;
   logic radix_low;
   logic unit_wait;
   logic out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign radix_low = (radix_ff < W'(2));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   hdbl_arith #(.LIMB_BITS(LIMB_BITS)) u_arith (
      .clock     (clock),
      .reset     (reset),
      .cmd       (acmd),
      .wide_init (a_wide_init),
      .mplr      (a_mplr),
      .aux       (a_aux),
      .wide_out  (a_wide),
      .rem_out   (a_rem),
      .quo_out   (a_quo),
      .stat      (astat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_command != CMD_NONE) begin
               state_in = radix_low ? ST_RESP : ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (!pend_ff && astat.done) begin
               state_in = (cmd_ff == CMD_FIRST) ? ST_EUC_TEST : ST_CHECK;
            end
         end
         ST_EUC_TEST: state_in = (r1_ff == '0) ? ST_CHECK : ST_EUC_DIV;
         ST_EUC_DIV:  if (!pend_ff && astat.done) state_in = ST_EUC_QMOD;
         ST_EUC_QMOD: if (!pend_ff && astat.done) state_in = ST_EUC_MUL;
         ST_EUC_MUL:  if (!pend_ff && astat.done) state_in = ST_EUC_MRED;
         ST_EUC_MRED: if (!pend_ff && astat.done) state_in = ST_EUC_UPD;
         ST_EUC_UPD:  state_in = ST_EUC_TEST;
         ST_CHECK:    state_in = miss_ff ? ST_RESP : ST_RED_A;
         ST_RED_A:    if (!pend_ff && astat.done) state_in = ST_RED_C;
         ST_RED_C:    if (!pend_ff && astat.done) state_in = ST_SUBW;
         ST_SUBW:     state_in = (cmd_ff == CMD_CLOSE) ? ST_RESP : ST_RED_INV;
         ST_RED_INV:  if (!pend_ff && astat.done) state_in = ST_QMUL;
         ST_QMUL:     if (!pend_ff && astat.done) state_in = ST_QRED;
         ST_QRED:     if (!pend_ff && astat.done) state_in = ST_PMUL;
         ST_PMUL:     if (!pend_ff && astat.done) state_in = ST_PDIV;
         ST_PDIV:     if (!pend_ff && astat.done) state_in = ST_RESP;
         ST_RESP:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      pend_in     = pend_ff;
      carry_in    = carry_ff;
      dinv_in     = dinv_ff;
      miss_in     = miss_ff;
      cmd_in      = cmd_ff;
      limb_in     = limb_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      qq_in       = qq_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      out_limb_in = out_limb_ff;
      out_flag_in = out_flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_limb_in  = rsp_limb_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_ninv_in  = rsp_ninv_ff;
      acmd.start    = 1'b0;
      acmd.op       = OP_DIV;
      acmd.long_run = 1'b0;
      a_wide_init   = {radix_ff, {W{1'b0}}};
      a_mplr        = '0;
      a_aux         = radix_ff;
      unit_wait     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in  = req_command;
               limb_in = req_dividend_limb;
               pend_in = 1'b1;
               if (req_command == CMD_FIRST) carry_in = '0;
               if (req_command != CMD_NONE && radix_low) begin
                  out_limb_in = '0;
                  out_flag_in = 1'b1;
                  if (req_command == CMD_FIRST) begin
                     miss_in = 1'b1;
                     dinv_in = '0;
                  end
               end
            end
         end
         ST_RED_B: begin
            unit_wait   = 1'b1;
            a_wide_init = {divisor_ff, {W{1'b0}}};
            if (!pend_ff && astat.done) begin
               b_in    = a_rem;
               r0_in   = radix_ff;
               r1_in   = a_rem;
               t0_in   = '0;
               t1_in   = W'(1);
               pend_in = 1'b1;
            end
         end
         ST_EUC_TEST: begin
            pend_in = 1'b1;
            if (r1_ff == '0) begin
               miss_in = (r0_ff != W'(1));
               dinv_in = (r0_ff == W'(1)) ? t0_ff : '0;
            end
         end
         ST_EUC_DIV: begin
            unit_wait   = 1'b1;
            a_wide_init = {r0_ff, {W{1'b0}}};
            a_aux       = r1_ff;
            if (!pend_ff && astat.done) begin
               qq_in   = a_quo;
               r0_in   = r1_ff;
               r1_in   = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_EUC_QMOD: begin
            unit_wait   = 1'b1;
            a_wide_init = {qq_ff, {W{1'b0}}};
            if (!pend_ff && astat.done) begin
               qq_in   = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_EUC_MUL: begin
            unit_wait = 1'b1;
            acmd.op   = OP_MUL;
            a_mplr    = qq_ff;
            a_aux     = t1_ff;
            if (!pend_ff && astat.done) pend_in = 1'b1;
         end
         ST_EUC_MRED: begin
            unit_wait     = 1'b1;
            acmd.long_run = 1'b1;
            a_wide_init   = a_wide;
            if (!pend_ff && astat.done) begin
               qq_in   = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_EUC_UPD: begin
            t0_in   = t1_ff;
            t1_in   = sub_mod(t0_ff, qq_ff, radix_ff);
            pend_in = 1'b1;
         end
         ST_CHECK: begin
            pend_in = 1'b1;
            if (miss_ff) begin
               out_limb_in = '0;
               out_flag_in = 1'b1;
            end
         end
         ST_RED_A: begin
            unit_wait   = 1'b1;
            a_wide_init = {limb_ff, {W{1'b0}}};
            if (!pend_ff && astat.done) begin
               limb_in = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_RED_C: begin
            unit_wait   = 1'b1;
            a_wide_init = {carry_ff, {W{1'b0}}};
            if (!pend_ff && astat.done) begin
               c_in    = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_SUBW: begin
            // limb now holds w = (a - c) mod B
            limb_in     = sub_mod(limb_ff, c_ff, radix_ff);
            out_limb_in = sub_mod(limb_ff, c_ff, radix_ff);
            out_flag_in = 1'b0;
            pend_in     = 1'b1;
         end
         ST_RED_INV: begin
            unit_wait   = 1'b1;
            a_wide_init = {dinv_ff, {W{1'b0}}};
            if (!pend_ff && astat.done) begin
               qq_in   = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_QMUL: begin
            unit_wait = 1'b1;
            acmd.op   = OP_MUL;
            a_mplr    = limb_ff;
            a_aux     = qq_ff;
            if (!pend_ff && astat.done) pend_in = 1'b1;
         end
         ST_QRED: begin
            unit_wait     = 1'b1;
            acmd.long_run = 1'b1;
            a_wide_init   = a_wide;
            if (!pend_ff && astat.done) begin
               qq_in   = a_rem;
               pend_in = 1'b1;
            end
         end
         ST_PMUL: begin
            unit_wait = 1'b1;
            acmd.op   = OP_MUL;
            a_mplr    = qq_ff;
            a_aux     = b_ff;
            if (!pend_ff && astat.done) pend_in = 1'b1;
         end
         ST_PDIV: begin
            // carry = (q*b + c) div B
            unit_wait     = 1'b1;
            acmd.long_run = 1'b1;
            a_wide_init   = a_wide + {{W{1'b0}}, c_ff};
            if (!pend_ff && astat.done) begin
               carry_in    = a_quo;
               out_limb_in = qq_ff;
               out_flag_in = 1'b0;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_limb_in  = out_limb_ff;
               rsp_rem_in   = (cmd_ff == CMD_CLOSE);
               rsp_ninv_in  = out_flag_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase

      // launch the unit once on entry to a compute state
      if (unit_wait && pend_ff) begin
         acmd.start = 1'b1;
         pend_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= W'(2);
         divisor_ff   <= W'(1);
         carry_ff     <= '0;
         dinv_ff      <= '0;
         miss_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         carry_ff     <= carry_in;
         dinv_ff      <= dinv_in;
         miss_ff      <= miss_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RADIX)   radix_ff   <= csr_data;
            if (csr_index == CSR_DIVISOR) divisor_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      limb_ff     <= limb_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      qq_ff       <= qq_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      out_limb_ff <= out_limb_in;
      out_flag_ff <= out_flag_in;
      rsp_limb_ff <= rsp_limb_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_ninv_ff <= rsp_ninv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_limb    = rsp_limb_ff;
   assign rsp_is_remainder   = rsp_rem_ff;
   assign rsp_not_invertible = rsp_ninv_ff;

   a_missing_zero_inv: assert property (@(posedge clock) disable iff (reset)
      miss_ff |-> (dinv_ff == '0))
      else $error("flagged run holds a nonzero inverse");

   a_unit_running: assert property (@(posedge clock) disable iff (reset)
      (unit_wait && !pend_ff) |-> (astat.busy || astat.done))
      else $error("sequencer waits on an idle unit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_limb_ff)
                                       && $stable(rsp_rem_ff) && $stable(rsp_ninv_ff)))
      else $error("stalled result word changed");

endmodule
